/* hw/rtl/first_fit_chunk_allocator_assert.svh */
// Assertion macros for the first-fit chunk allocator.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("allocator property violated");
`define FFCA_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("allocator forbidden condition seen");
`else
`define FFCA_ASSERT(lbl, prop)
`define FFCA_NEVER(lbl, cond)
`endif
`endif

/* hw/rtl/ffca_pkg.sv */
// Shared constants, types and codes of the first-fit chunk allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;
	localparam int PAGE_BYTES  = 4096;
	localparam int ALIGN_BYTES = 256;
	localparam int PAGE_LIMIT  = 4;
	localparam int CHUNK_SLOTS = 16;

	localparam int PAGE_UNITS = PAGE_BYTES / ALIGN_BYTES;
	localparam int OFF_W      = $clog2(PAGE_UNITS);
	localparam int LEN_W      = OFF_W + 1;
	localparam int SLOT_W     = $clog2(CHUNK_SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int PG_W       = $clog2(PAGE_LIMIT);
	localparam int PGC_W      = PG_W + 1;
	localparam int MADDR_W    = PG_W + SLOT_W;
	localparam int ALIGN_SH   = $clog2(ALIGN_BYTES);
	localparam int PAGE_SH    = $clog2(PAGE_BYTES);
	localparam int ADDR_W     = 14;
	localparam int SIZE_W     = 16;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 3;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_SPACE     = 3'd1;
	localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_IN_PAGE  = 3'd4;

	// One chunk table entry, offset and length in alignment units.
	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic             taken;
	} chunk_t;
endpackage
`default_nettype wire

/* hw/rtl/ffca_chunk_ram.sv */
// Chunk table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffca_chunk_ram import ffca_pkg::*; (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [MADDR_W-1:0] waddr,
	input  wire chunk_t             wdata,
	input  wire logic [MADDR_W-1:0] raddr,
	output chunk_t                  rdata
);
	chunk_t mem [PAGE_LIMIT*CHUNK_SLOTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/first_fit_chunk_allocator.sv */
// Top level of the first-fit chunk allocator with free-chunk coalescing.
//
//  channel  | direction | tdata                          | tuser
//  ---------+-----------+--------------------------------+-------------
//  s_*      | in        | request_size, block_address    | command
//  m_*      | out       | granted_address                | status
//
// One request is worked at a time; the chunk table sits in one memory with a
// registered read, so every table step is a read, then a use of the data.
// Allocate scans the slots page by page and moves entries up on a split.
// Free scans the slots of its page, then passes over that page to coalesce.
// Reset clears the page counts, not the table; the table needs no clearing pass.
// A finished result waits in the output register while m_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_chunk_allocator_assert.svh"
module first_fit_chunk_allocator import ffca_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // request_size[15:0], block_address[29:16]
	input  wire logic [1:0]  s_tuser,  // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // granted_address[13:0]
	output logic [2:0]       m_tuser   // status[2:0]
);
	typedef enum logic [14:0] {
		ST_IDLE     = 15'b000000000000001,
		ST_ASCAN_RD = 15'b000000000000010,
		ST_ASCAN_EV = 15'b000000000000100,
		ST_NEW_A    = 15'b000000000001000,
		ST_NEW_B    = 15'b000000000010000,
		ST_SH_RD    = 15'b000000000100000,
		ST_SH_WR    = 15'b000000001000000,
		ST_SPLIT_W  = 15'b000000010000000,
		ST_TAKE_W   = 15'b000000100000000,
		ST_FSCAN_RD = 15'b000001000000000,
		ST_FSCAN_EV = 15'b000010000000000,
		ST_MG_RD    = 15'b000100000000000,
		ST_MG_EV    = 15'b001000000000000,
		ST_MG_FLUSH = 15'b010000000000000,
		ST_FIN      = 15'b100000000000000
	} fsm_t;

	fsm_t               state_q;
	logic [CNT_W-1:0]   tot_q [PAGE_LIMIT];
	logic [PGC_W-1:0]   pages_q;
	logic [PGC_W-1:0]   pg_q;
	logic [CNT_W-1:0]   s_q, j_q, hit_q, r_q, w_q;
	logic [LEN_W-1:0]   need_q;
	logic [OFF_W-1:0]   offu_q;
	logic               split_q, have_q;
	chunk_t             ent_q, pend_q;
	logic [STAT_W-1:0]  res_status_q, out_status_q;
	logic [ADDR_W-1:0]  res_addr_q, out_addr_q;
	logic               out_valid_q;

	logic               we;
	logic [MADDR_W-1:0] waddr, raddr;
	chunk_t             wdata, rdata, mg_e;
	logic [CNT_W-1:0]   tot_cur;
	logic [PG_W-1:0]    pgi;
	logic [SIZE_W-1:0]  in_size;
	logic [ADDR_W-1:0]  in_addr;
	logic [SIZE_W:0]    size_round;
	logic [LEN_W-1:0]   mg_end;
	logic               out_free;

	assign in_size    = s_tdata[SIZE_W-1:0];
	assign in_addr    = s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
	assign size_round = {1'b0, in_size} + (SIZE_W+1)'(ALIGN_BYTES - 1);
	assign pgi        = pg_q[PG_W-1:0];
	assign tot_cur    = tot_q[pgi];
	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {(16-ADDR_W)'(0), out_addr_q};
	assign m_tuser    = out_status_q;

	// Entry seen by the coalescing pass, with the freed slot marked free.
	always_comb begin
		mg_e = rdata;
		if (r_q == hit_q) begin
			mg_e.taken = 1'b0;
		end
	end
	assign mg_end = LEN_W'(pend_q.off) + pend_q.len;

	ffca_chunk_ram u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Read address per state.
	always_comb begin
		case (state_q)
			ST_SH_RD: raddr = {pgi, j_q[SLOT_W-1:0]};
			ST_MG_RD: raddr = {pgi, r_q[SLOT_W-1:0]};
			default:  raddr = {pgi, s_q[SLOT_W-1:0]};
		endcase
	end

	// Table writes per state.
	always_comb begin
		we    = 1'b0;
		waddr = {pgi, s_q[SLOT_W-1:0]};
		wdata = ent_q;
		case (state_q)
			ST_NEW_A: begin
				we          = 1'b1;
				waddr       = {pgi, SLOT_W'(0)};
				wdata.off   = '0;
				wdata.len   = need_q;
				wdata.taken = 1'b1;
			end
			ST_NEW_B: begin
				we          = 1'b1;
				waddr       = {pgi, SLOT_W'(1)};
				wdata.off   = need_q[OFF_W-1:0];
				wdata.len   = LEN_W'(PAGE_UNITS) - need_q;
				wdata.taken = 1'b0;
			end
			ST_SH_WR: begin
				we    = 1'b1;
				waddr = {pgi, SLOT_W'(j_q + CNT_W'(1))};
				wdata = rdata;
			end
			ST_SPLIT_W: begin
				we          = 1'b1;
				waddr       = {pgi, SLOT_W'(s_q + CNT_W'(1))};
				wdata.off   = ent_q.off + need_q[OFF_W-1:0];
				wdata.len   = ent_q.len - need_q;
				wdata.taken = 1'b0;
			end
			ST_TAKE_W: begin
				we          = 1'b1;
				wdata.len   = split_q ? need_q : ent_q.len;
				wdata.taken = 1'b1;
			end
			ST_MG_EV: begin
				we    = have_q && !(!pend_q.taken && !mg_e.taken
					&& mg_end == LEN_W'(mg_e.off));
				waddr = {pgi, w_q[SLOT_W-1:0]};
				wdata = pend_q;
			end
			ST_MG_FLUSH: begin
				we    = 1'b1;
				waddr = {pgi, w_q[SLOT_W-1:0]};
				wdata = pend_q;
			end
			default: ;
		endcase
	end

	// Control state and page bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pages_q     <= '0;
			out_valid_q <= 1'b0;
			for (int p = 0; p < PAGE_LIMIT; p++) begin
				tot_q[p] <= '0;
			end
		end else begin
			// A new result replaces the old one, otherwise a taken result leaves.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							CMD_ALLOC: begin
								if (in_size == '0 || in_size > SIZE_W'(PAGE_BYTES)) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_ASCAN_RD;
								end
							end
							CMD_FREE: begin
								if ({1'b0, in_addr[ADDR_W-1:PAGE_SH]} >= pages_q) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_FSCAN_RD;
								end
							end
							CMD_CLEAR: begin
								pages_q <= '0;
								for (int p = 0; p < PAGE_LIMIT; p++) begin
									tot_q[p] <= '0;
								end
								state_q <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_ASCAN_RD: begin
					if (pg_q >= pages_q) begin
						if (pages_q == PGC_W'(PAGE_LIMIT)) begin
							state_q <= ST_FIN;
						end else begin
							pages_q <= pages_q + PGC_W'(1);
							state_q <= ST_NEW_A;
						end
					end else if (s_q < tot_cur) begin
						state_q <= ST_ASCAN_EV;
					end
				end
				ST_ASCAN_EV: begin
					if (!rdata.taken && rdata.len >= need_q) begin
						if (rdata.len > need_q && tot_cur < CNT_W'(CHUNK_SLOTS)) begin
							state_q <= ST_SH_RD;
						end else begin
							state_q <= ST_TAKE_W;
						end
					end else begin
						state_q <= ST_ASCAN_RD;
					end
				end
				ST_NEW_A: begin
					if (need_q != LEN_W'(PAGE_UNITS)) begin
						tot_q[pgi] <= CNT_W'(2);
						state_q    <= ST_NEW_B;
					end else begin
						tot_q[pgi] <= CNT_W'(1);
						state_q    <= ST_FIN;
					end
				end
				ST_NEW_B: state_q <= ST_FIN;
				ST_SH_RD: state_q <= (j_q > s_q) ? ST_SH_WR : ST_SPLIT_W;
				ST_SH_WR: state_q <= ST_SH_RD;
				ST_SPLIT_W: begin
					tot_q[pgi] <= tot_cur + CNT_W'(1);
					state_q    <= ST_TAKE_W;
				end
				ST_TAKE_W: state_q <= ST_FIN;
				ST_FSCAN_RD: state_q <= (s_q < tot_cur) ? ST_FSCAN_EV : ST_FIN;
				ST_FSCAN_EV: begin
					if (rdata.off == offu_q && res_status_q == ST_OK) begin
						state_q <= rdata.taken ? ST_MG_RD : ST_FIN;
					end else begin
						state_q <= ST_FSCAN_RD;
					end
				end
				ST_MG_RD: state_q <= (r_q < tot_cur) ? ST_MG_EV : ST_MG_FLUSH;
				ST_MG_EV: state_q <= ST_MG_RD;
				ST_MG_FLUSH: begin
					tot_q[pgi] <= w_q + CNT_W'(1);
					state_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q        <= '0;
				need_q     <= LEN_W'(size_round >> ALIGN_SH);
				offu_q     <= in_addr[PAGE_SH-1:ALIGN_SH];
				res_addr_q <= '0;
				if (s_tuser == CMD_FREE) begin
					pg_q <= {1'b0, in_addr[ADDR_W-1:PAGE_SH]};
					if ({1'b0, in_addr[ADDR_W-1:PAGE_SH]} >= pages_q) begin
						res_status_q <= ST_NOT_IN_PAGE;
					end else if (in_addr[ALIGN_SH-1:0] != '0) begin
						// Unaligned offsets never start a chunk; keep scanning to miss.
						res_status_q <= ST_NOT_FOUND;
					end else begin
						res_status_q <= ST_OK;
					end
				end else begin
					pg_q         <= '0;
					res_status_q <= (s_tuser == CMD_ALLOC) ? ST_NO_SPACE : ST_OK;
				end
			end
			ST_ASCAN_RD: begin
				if (pg_q >= pages_q) begin
					if (pages_q != PGC_W'(PAGE_LIMIT)) begin
						pg_q         <= pages_q;
						res_status_q <= ST_OK;
						res_addr_q   <= ADDR_W'(pages_q) << PAGE_SH;
					end
				end else if (s_q >= tot_cur) begin
					pg_q <= pg_q + PGC_W'(1);
					s_q  <= '0;
				end
			end
			ST_ASCAN_EV: begin
				ent_q <= rdata;
				j_q   <= tot_cur - CNT_W'(1);
				if (!rdata.taken && rdata.len >= need_q) begin
					split_q      <= rdata.len > need_q && tot_cur < CNT_W'(CHUNK_SLOTS);
					res_status_q <= ST_OK;
					res_addr_q   <= (ADDR_W'(pgi) << PAGE_SH)
						| (ADDR_W'(rdata.off) << ALIGN_SH);
				end else begin
					s_q <= s_q + CNT_W'(1);
				end
			end
			ST_SH_WR: j_q <= j_q - CNT_W'(1);
			ST_FSCAN_RD: begin
				if (s_q >= tot_cur) begin
					res_status_q <= ST_NOT_FOUND;
				end
			end
			ST_FSCAN_EV: begin
				if (rdata.off == offu_q && res_status_q == ST_OK) begin
					hit_q  <= s_q;
					r_q    <= '0;
					w_q    <= '0;
					have_q <= 1'b0;
					if (!rdata.taken) begin
						res_status_q <= ST_ALREADY_FREE;
					end
				end else begin
					s_q <= s_q + CNT_W'(1);
				end
			end
			ST_MG_EV: begin
				// Coalesce neighbouring free chunks as the page streams past.
				r_q    <= r_q + CNT_W'(1);
				have_q <= 1'b1;
				if (!have_q) begin
					pend_q <= mg_e;
				end else if (!pend_q.taken && !mg_e.taken && mg_end == LEN_W'(mg_e.off)) begin
					pend_q.len <= pend_q.len + mg_e.len;
				end else begin
					pend_q <= mg_e;
					w_q    <= w_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_addr_q   <= (res_status_q == ST_OK) ? res_addr_q : '0;
		end
	end

	`FFCA_NEVER(a_pages_bound, pages_q > PGC_W'(PAGE_LIMIT))
	`FFCA_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
	`FFCA_ASSERT(a_result_from_fin, $rose(m_tvalid) |-> $past(state_q == ST_FIN))
endmodule
`default_nettype wire
